// ===== design/sorted_process_queue_unit_assert.svh =====
// Assertion macros used by the sorted process queue top level.
`ifndef SORTED_PROCESS_QUEUE_UNIT_ASSERT_SVH
`define SORTED_PROCESS_QUEUE_UNIT_ASSERT_SVH

// Property checked on clk_i and switched off while rst_ni is low.
`define SPQ_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property checked on clk_i at every edge, reset included.
`define SPQ_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ===== design/spq_pkg.sv =====
// Types, codes and the ordering function of the sorted process queue.
`timescale 1ns / 1ps
package spq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  localparam int unsigned ID_W     = 8;
  localparam int unsigned TIME_W   = 16;
  localparam int unsigned PRIO_W   = 8;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 5;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  localparam logic POLICY_BURST = 1'b0;
  localparam logic POLICY_PRIO  = 1'b1;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] arrival;
    logic [TIME_W-1:0] burst;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // True when entry a has to stand in front of held entry b.
  function automatic logic goes_before(entry_t a, entry_t b, logic policy);
    logic res;
    if (a.arrival != b.arrival) begin
      res = (a.arrival < b.arrival);
    end else if ((policy == POLICY_PRIO) && (a.prio != b.prio)) begin
      res = (a.prio > b.prio);
    end else begin
      res = (a.burst < b.burst);
    end
    return res;
  endfunction

endpackage

// ===== design/sorted_process_queue_unit.sv =====
// Top level of the sorted process queue: entry memory, walk sequencer and result register.
`timescale 1ns / 1ps
// The sorted process queue holds up to QueueDepth process entries in one
// single-port-read, single-port-write memory, kept in order of arrival time,
// with arrival ties broken by shorter burst (tie_policy 0) or by higher
// priority and then shorter burst (tie_policy 1). Each word on the input
// channel either inserts an entry (placed behind every entry equal to it) or
// removes the first entry, counted from the head, with the given id. Each
// word gives back exactly one result word with a status (ok, full, id not
// found), the count after the operation and the head entry, which reads as
// all zeros when the queue is empty. An operation walks the memory once from
// the head, one entry per cycle, reading the next entry while it writes the
// current one back one place up (insert) or down (remove); the registered
// read of that memory sets the pace. A new word is accepted only once the
// result of the last one has left the sequencer; an insert into a full
// queue skips the walk. The result register lets the next word be accepted
// while a result still waits to be taken. The memory needs no clearing after
// reset: only the first count entries are ever used. The configuration
// register is written over its own channel and is always ready; it should be
// written while the block is idle.
module sorted_process_queue_unit #(
  parameter int unsigned QueueDepth = spq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic                          cfg_wdata_i,
  // input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [spq_pkg::ID_W-1:0]      proc_id_i,
  input  logic [spq_pkg::TIME_W-1:0]    arrival_time_i,
  input  logic [spq_pkg::TIME_W-1:0]    burst_time_i,
  input  logic [spq_pkg::PRIO_W-1:0]    priority_level_i,
  // output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [spq_pkg::STATUS_W-1:0]  status_o,
  output logic [spq_pkg::COUNT_W-1:0]   queue_count_o,
  output logic                          head_valid_o,
  output logic [spq_pkg::ID_W-1:0]      head_id_o,
  output logic [spq_pkg::TIME_W-1:0]    head_arrival_o,
  output logic [spq_pkg::TIME_W-1:0]    head_burst_o,
  output logic [spq_pkg::PRIO_W-1:0]    head_priority_o
);

  import spq_pkg::*;

  `include "sorted_process_queue_unit_assert.svh"

  // Address width of the memory and width of a count that can reach the depth.
  localparam int unsigned AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CW = $clog2(QueueDepth + 1);
  localparam logic [CW-1:0] DEPTH_CNT = CW'(QueueDepth);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_WALK = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  // Control registers.
  logic [1:0]          state_q, state_d;
  logic [CW-1:0]       occ_q, occ_d;
  logic [CW-1:0]       cur_q, cur_d;
  logic                op_q, op_d;
  logic                placed_q, placed_d;
  logic                found_q, found_d;
  logic                policy_q;
  logic                out_valid_q, out_valid_d;

  // Payload registers.
  entry_t              new_q, new_d;
  entry_t              carry_q, carry_d;
  entry_t              head_q;
  logic [STATUS_W-1:0] res_status_q, res_status_d;
  logic [STATUS_W-1:0] out_status_q;
  logic [COUNT_W-1:0]  out_count_q;
  logic                out_head_valid_q;
  entry_t              out_head_q;

  // Entry memory and its ports.
  entry_t              mem [QueueDepth];
  entry_t              rdata_q;
  logic [AW-1:0]       raddr;
  logic                mem_we;
  logic [AW-1:0]       waddr;
  entry_t              wdata;

  logic                in_fire;
  logic                out_load;
  logic [CW-1:0]       cur_next;
  logic [CW-1:0]       cur_prev;
  logic [31:0]         occ_wide;
  entry_t              in_entry;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;

  assign in_entry.id      = proc_id_i;
  assign in_entry.arrival = arrival_time_i;
  assign in_entry.burst   = burst_time_i;
  assign in_entry.prio    = priority_level_i;

  assign cur_next = cur_q + CW'(1);
  assign cur_prev = cur_q - CW'(1);

  // While idle the head entry is fetched so that a walk starts with it in
  // hand; during a walk the entry after the current one is fetched.
  assign raddr = (state_q == ST_IDLE) ? '0 : cur_next[AW-1:0];

  // A result can leave the sequencer once the output register is free or
  // is being emptied in the same cycle.
  assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    occ_d        = occ_q;
    cur_d        = cur_q;
    op_d         = op_q;
    placed_d     = placed_q;
    found_d      = found_q;
    new_d        = new_q;
    carry_d      = carry_q;
    res_status_d = res_status_q;
    mem_we       = 1'b0;
    waddr        = cur_q[AW-1:0];
    wdata        = new_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          op_d     = mode_i;
          new_d    = in_entry;
          cur_d    = '0;
          placed_d = 1'b0;
          found_d  = 1'b0;
          if ((mode_i == MODE_INSERT) && (occ_q >= DEPTH_CNT)) begin
            res_status_d = STATUS_FULL;
            state_d      = ST_DONE;
          end else begin
            state_d = ST_WALK;
          end
        end
      end

      ST_WALK: begin
        if (cur_q == occ_q) begin
          // Past the last held entry: close the walk.
          if (op_q == MODE_INSERT) begin
            mem_we       = 1'b1;
            waddr        = occ_q[AW-1:0];
            wdata        = placed_q ? carry_q : new_q;
            occ_d        = occ_q + CW'(1);
            res_status_d = STATUS_OK;
          end else if (found_q) begin
            occ_d        = occ_q - CW'(1);
            res_status_d = STATUS_OK;
          end else begin
            res_status_d = STATUS_NOT_FOUND;
          end
          state_d = ST_DONE;
        end else begin
          if (op_q == MODE_INSERT) begin
            // Once the new entry is placed, every later entry moves up one.
            if (placed_q) begin
              mem_we  = 1'b1;
              wdata   = carry_q;
              carry_d = rdata_q;
            end else if (goes_before(new_q, rdata_q, policy_q)) begin
              mem_we   = 1'b1;
              wdata    = new_q;
              carry_d  = rdata_q;
              placed_d = 1'b1;
            end
          end else begin
            // Behind the removed entry, every entry moves down one.
            if (found_q) begin
              mem_we = 1'b1;
              waddr  = cur_prev[AW-1:0];
              wdata  = rdata_q;
            end else if (rdata_q.id == new_q.id) begin
              found_d = 1'b1;
            end
          end
          cur_d = cur_next;
        end
      end

      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      occ_q       <= '0;
      cur_q       <= '0;
      op_q        <= MODE_INSERT;
      placed_q    <= 1'b0;
      found_q     <= 1'b0;
      policy_q    <= POLICY_BURST;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      occ_q       <= occ_d;
      cur_q       <= cur_d;
      op_q        <= op_d;
      placed_q    <= placed_d;
      found_q     <= found_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        policy_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    new_q        <= new_d;
    carry_q      <= carry_d;
    res_status_q <= res_status_d;
  end

  // Entry memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Copy of the head entry, kept current by watching writes to the first slot.
  always_ff @(posedge clk_i) begin
    if (mem_we && (waddr == '0)) begin
      head_q <= wdata;
    end
  end

  assign occ_wide = 32'(occ_q);

  // Result register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_status_q     <= res_status_q;
      out_count_q      <= occ_wide[COUNT_W-1:0];
      out_head_valid_q <= (occ_q != '0);
      out_head_q       <= (occ_q != '0) ? head_q : '0;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign status_o        = out_status_q;
  assign queue_count_o   = out_count_q;
  assign head_valid_o    = out_head_valid_q;
  assign head_id_o       = out_head_q.id;
  assign head_arrival_o  = out_head_q.arrival;
  assign head_burst_o    = out_head_q.burst;
  assign head_priority_o = out_head_q.prio;

  `SPQ_ASSERT(a_occ_bounded, occ_q <= DEPTH_CNT, "queue count above depth")
  `SPQ_ASSERT(a_occ_step, (occ_q == $past(occ_q)) || (occ_q == $past(occ_q) + CW'(1)) || (occ_q == $past(occ_q) - CW'(1)), "queue count moved by more than one")
  `SPQ_ASSERT(a_write_in_walk, mem_we |-> (state_q == ST_WALK), "memory written outside a walk")
  `SPQ_ASSERT(a_full_status, ((state_q == ST_DONE) && (res_status_q == STATUS_FULL)) |-> (occ_q == DEPTH_CNT), "full status with room left")
  `SPQ_ASSERT_ALWAYS(a_found_remove, found_q |-> (op_q == MODE_REMOVE), "match flag set on an insert")

endmodule
